### hw/rtl/sha256h_pkg.sv
package sha256h_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int LEN_POS     = 56;
	localparam int ROUNDS      = 64;
	localparam int DIGEST_WORDS = 8;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic FUNC_ABSORB = 1'b0;
	localparam logic FUNC_FINISH = 1'b1;

	typedef struct packed {
		logic       func;
		logic [7:0] byte_value;
	} item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_t;

	// Working variables a..h, with a at index 0.
	typedef logic [7:0][31:0] work_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_PAD    = 6'b000010,
		ST_LEN    = 6'b000100,
		ST_ROUND  = 6'b001000,
		ST_UPDATE = 6'b010000,
		ST_EMIT   = 6'b100000
	} state_t;

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

### hw/rtl/sha256_message_hasher.sv
// Absorb requests are taken one per cycle while the block is idle; the 64th byte of a
// block starts a compression: the rounds on the shared round unit, then a fold of the
// result into the hash. A finish request feeds 9 to 72 padding and length bytes one
// per cycle outside compressions, with a step that pushes nothing before the length
// bytes and one or two compressions, then offers eight digest words.
// The input stalls until the last digest word is taken. Reset loads the initial
// hash, clears the byte count and bit length, and leaves the block idle.
module sha256_message_hasher (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  sha256h_pkg::item_t   item,
	output logic                 digest_valid,
	input  logic                 digest_stall,
	output sha256h_pkg::digest_t digest
);
	import sha256h_pkg::*;

	localparam logic [5:0] FILL_LAST = 6'(BLOCK_BYTES - 1);
	localparam logic [5:0] FILL_LEN  = 6'(LEN_POS);
	localparam logic [5:0] RND_LAST  = 6'(ROUNDS - 1);
	localparam logic [2:0] IDX_LAST  = 3'(DIGEST_WORDS - 1);

	state_t       state_q;
	logic [5:0]   fill_q;
	logic [63:0]  bits_q;
	logic [31:0]  hash_q [8];
	logic         fin_q;
	logic         len_q;
	logic         pad_first_q;
	logic [2:0]   len_cnt_q;
	logic [5:0]   rnd_q;
	logic [2:0]   idx_q;
	logic [511:0] buf_q;
	work_t        v_q;

	logic         push_en;
	logic [7:0]   push_byte;
	logic         wrap;
	logic [7:0]   len_byte;
	work_t        v_next;
	logic [31:0]  w_new;

	sha256h_round u_round (
		.work      (v_q),
		.w0        (buf_q[511:480]),
		.w1        (buf_q[479:448]),
		.w9        (buf_q[223:192]),
		.w14       (buf_q[63:32]),
		.k         (ROUND_K[rnd_q]),
		.work_next (v_next),
		.w_new     (w_new)
	);

	// Length bytes go out most significant first.
	assign len_byte = bits_q[{~len_cnt_q, 3'b000} +: 8];

	always_comb begin
		push_en   = 1'b0;
		push_byte = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid && item.func == FUNC_ABSORB) begin
					push_en   = 1'b1;
					push_byte = item.byte_value;
				end
			end
			ST_PAD: begin
				if (pad_first_q || fill_q != FILL_LEN) begin
					push_en   = 1'b1;
					push_byte = pad_first_q ? PAD_BYTE : 8'h00;
				end
			end
			ST_LEN: begin
				push_en   = 1'b1;
				push_byte = len_byte;
			end
			default: begin
			end
		endcase
	end

	assign wrap = push_en && fill_q == FILL_LAST;

	assign item_stall   = state_q != ST_IDLE;
	assign digest_valid = state_q == ST_EMIT;
	assign digest.digest_word = hash_q[idx_q];
	assign digest.word_index  = idx_q;
	assign digest.last_word   = idx_q == IDX_LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			bits_q      <= '0;
			fin_q       <= 1'b0;
			len_q       <= 1'b0;
			pad_first_q <= 1'b0;
			len_cnt_q   <= '0;
			rnd_q       <= '0;
			idx_q       <= '0;
			for (int i = 0; i < 8; i++) hash_q[i] <= INIT_H[i];
		end else begin
			if (push_en) fill_q <= fill_q + 6'd1;
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (item.func == FUNC_ABSORB) begin
							bits_q <= bits_q + 64'd8;
							if (wrap) state_q <= ST_ROUND;
						end else begin
							fin_q       <= 1'b1;
							pad_first_q <= 1'b1;
							state_q     <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pad_first_q <= 1'b0;
					if (wrap) begin
						state_q <= ST_ROUND;
					end else if (!push_en) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					len_cnt_q <= len_cnt_q + 3'd1;
					if (wrap) begin
						len_q   <= 1'b1;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == RND_LAST) state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
					if (!fin_q) begin
						state_q <= ST_IDLE;
					end else if (len_q) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_EMIT: begin
					if (!digest_stall) begin
						if (idx_q == IDX_LAST) begin
							idx_q   <= '0;
							bits_q  <= '0;
							fin_q   <= 1'b0;
							len_q   <= 1'b0;
							state_q <= ST_IDLE;
							for (int i = 0; i < 8; i++) hash_q[i] <= INIT_H[i];
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The byte buffer doubles as the message schedule window during rounds.
	always_ff @(posedge clk) begin
		if (push_en) buf_q <= {buf_q[503:0], push_byte};
		if (state_q == ST_ROUND) begin
			buf_q <= {buf_q[479:0], w_new};
			v_q   <= v_next;
		end
		if (wrap) begin
			for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
		end
	end

	a_round_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_ROUND |-> rnd_q == '0)
		else $error("round counter not at zero outside a compression");

	a_emit_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> fill_q == '0 && len_cnt_q == '0)
		else $error("digest offered with pending bytes");

	a_len_fill: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LEN |-> fill_q == FILL_LEN + 6'(len_cnt_q))
		else $error("length bytes out of place in the block");

	a_clear_after: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid && !digest_stall && digest.last_word |=>
			state_q == ST_IDLE && bits_q == '0 && !fin_q)
		else $error("hasher not cleared after the last digest word");

endmodule

### hw/rtl/sha256h_round.sv
module sha256h_round (
	input  sha256h_pkg::work_t work,
	input  logic [31:0]        w0,
	input  logic [31:0]        w1,
	input  logic [31:0]        w9,
	input  logic [31:0]        w14,
	input  logic [31:0]        k,
	output sha256h_pkg::work_t work_next,
	output logic [31:0]        w_new
);
	import sha256h_pkg::*;

	logic [31:0] big1, big0, ch, maj, t1, t2, sig0, sig1;

	always_comb begin
		big1 = rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25);
		ch   = (work[4] & work[5]) ^ (~work[4] & work[6]);
		t1   = work[7] + big1 + ch + k + w0;
		big0 = rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22);
		maj  = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
		t2   = big0 + maj;

		work_next[7] = work[6];
		work_next[6] = work[5];
		work_next[5] = work[4];
		work_next[4] = work[3] + t1;
		work_next[3] = work[2];
		work_next[2] = work[1];
		work_next[1] = work[0];
		work_next[0] = t1 + t2;

		// Next schedule word from the sliding sixteen-word window.
		sig0  = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
		sig1  = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
		w_new = sig1 + w9 + sig0 + w0;
	end

endmodule
